// ===== design/mpa_pkg.sv =====
// Shared constants for the 2-D max pooling unit with argmax.
// Holds register indexes, register reset values and fixed field widths.
// No dependencies.
package mpa_pkg;

	// Width of the flat input and output indexes on the result word.
	localparam int IDX_W = 18;

	// Configuration port geometry.
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 3;
	localparam int DIM_REG_W   = 7;
	localparam int POOL_REG_W  = 4;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_INPUT_HEIGHT  = 3'd0;
	localparam cfg_index_t REG_INPUT_WIDTH   = 3'd1;
	localparam cfg_index_t REG_CHANNEL_COUNT = 3'd2;
	localparam cfg_index_t REG_POOL_HEIGHT   = 3'd3;
	localparam cfg_index_t REG_POOL_WIDTH    = 3'd4;
	localparam cfg_index_t REG_STRIDE_ROWS   = 3'd5;
	localparam cfg_index_t REG_STRIDE_COLS   = 3'd6;

	localparam logic [DIM_REG_W-1:0]  RST_INPUT_HEIGHT  = 7'd8;
	localparam logic [DIM_REG_W-1:0]  RST_INPUT_WIDTH   = 7'd8;
	localparam logic [DIM_REG_W-1:0]  RST_CHANNEL_COUNT = 7'd1;
	localparam logic [POOL_REG_W-1:0] RST_POOL_HEIGHT   = 4'd2;
	localparam logic [POOL_REG_W-1:0] RST_POOL_WIDTH    = 4'd2;
	localparam logic [POOL_REG_W-1:0] RST_STRIDE_ROWS   = 4'd2;
	localparam logic [POOL_REG_W-1:0] RST_STRIDE_COLS   = 4'd2;

endpackage

// ===== design/max_pool_2d_argmax_unit.sv =====
// Top level of the streaming 2-D max pooling unit with argmax.
// Depends on mpa_pkg (constants) and mpa_ram (plane store).
//
// Usage:
// Samples enter on the in_valid/in_ready channel, channels first and raster
// order within a plane. Each sample is written to the plane store. A sample
// that is the bottom-right corner of a pooling window starts a scan of that
// window; the result word (max_value, winner_index, output_index, frame_last)
// leaves on the out_valid/out_ready channel through an output register.
// A sample that closes no window leaves the block in idle, where the next
// sample can be taken. A sample that closes a window starts a scan of it:
// the plane store has one read port, so the window is read one element per
// cycle in the scan state; the drain state then compares the last element,
// loads the output register and returns to idle. No sample is taken meanwhile.
// When the receiver stalls, samples that close no window are still taken; a
// sample that closes a window waits until the output register is empty.
// Reset puts the registers at their defaults and the position at the start
// of a frame. The cycle after reset, or after a register write while idle,
// reloads the window trackers and holds in_ready low; such a write restarts
// the frame. Writes must go in only while idle; the block does not enforce it.
module max_pool_2d_argmax_unit #(
	parameter int MAX_DIM      = 64,
	parameter int MAX_CHANNELS = 64,
	parameter int MAX_POOL     = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [mpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mpa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]      max_value,
	output logic [mpa_pkg::IDX_W-1:0]          winner_index,
	output logic [mpa_pkg::IDX_W-1:0]          output_index,
	output logic                               frame_last
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
	localparam int POOL_W = $clog2(MAX_POOL + 1);
	localparam int NE_W   = $clog2(MAX_DIM + MAX_POOL + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int AW     = $clog2(DEPTH);
	localparam int LIN_W  = 2 * DIM_W;
	localparam int PROD_W = POOL_W + DIM_W;
	localparam int IW     = mpa_pkg::IDX_W;
	localparam logic [LIN_W-1:0] ADDR_MASK = LIN_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [mpa_pkg::DIM_REG_W-1:0]  ih_reg_q, iw_reg_q, nc_reg_q;
	logic [mpa_pkg::POOL_REG_W-1:0] ph_reg_q, pw_reg_q, sr_reg_q, sc_reg_q;

	// Clamped settings.
	logic [DIM_W-1:0]  ih, iw;
	logic [CH_W-1:0]   nc;
	logic [POOL_W-1:0] ph, pw, sr, sc;

	// Position of the next sample and window trackers.
	logic [DIM_W-1:0] r_q, c_q;
	logic [CH_W-1:0]  ch_q;
	logic [NE_W-1:0]  nre_q, nce_q;
	logic [IW-1:0]    flat_q, oidx_q;
	logic             restart_q;

	// Window scan.
	logic [DIM_W-1:0]  srow_q, scol_q, c0_q;
	logic [POOL_W-1:0] kr_q, kc_q;
	logic [IW-1:0]     sflat_q, rstep_q;
	logic [IW-1:0]     oidx_hit_q;
	logic              last_hit_q;

	// Compare stage.
	logic                          valid_s1, first_s1, last_s1;
	logic [IW-1:0]                 flat_s1;
	logic signed [SAMPLE_BITS-1:0] best_q;
	logic [IW-1:0]                 bidx_q;

	// Output register.
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic [IW-1:0]                 out_win_q, out_oidx_q;
	logic                          out_last_q;

	logic                          cfg_hit, accept, hit, frame_last_now, scan_last, take;
	logic                          frame_end;
	logic [NE_W:0]                 row_reach, col_reach;
	logic [PROD_W-1:0]             up_prod;
	logic [IW-1:0]                 start_flat;
	logic [AW-1:0]                 waddr, raddr;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic signed [SAMPLE_BITS-1:0] new_best;
	logic [IW-1:0]                 new_idx;

	function automatic logic [AW-1:0] plane_addr(input logic [DIM_W-1:0] row,
		input logic [DIM_W-1:0] col);
		logic [LIN_W-1:0] lin;
		lin = LIN_W'(row) * LIN_W'(MAX_DIM) + LIN_W'(col);
		return AW'(lin & ADDR_MASK);
	endfunction

	// Clamp the registers into their legal ranges.
	always_comb begin
		if (ih_reg_q == '0) ih = DIM_W'(1);
		else if (32'(ih_reg_q) > MAX_DIM) ih = DIM_W'(MAX_DIM);
		else ih = DIM_W'(ih_reg_q);
		if (iw_reg_q == '0) iw = DIM_W'(1);
		else if (32'(iw_reg_q) > MAX_DIM) iw = DIM_W'(MAX_DIM);
		else iw = DIM_W'(iw_reg_q);
		if (nc_reg_q == '0) nc = CH_W'(1);
		else if (32'(nc_reg_q) > MAX_CHANNELS) nc = CH_W'(MAX_CHANNELS);
		else nc = CH_W'(nc_reg_q);
		if (ph_reg_q == '0) ph = POOL_W'(1);
		else if (32'(ph_reg_q) > MAX_POOL) ph = POOL_W'(MAX_POOL);
		else ph = POOL_W'(ph_reg_q);
		if (pw_reg_q == '0) pw = POOL_W'(1);
		else if (32'(pw_reg_q) > MAX_POOL) pw = POOL_W'(MAX_POOL);
		else pw = POOL_W'(pw_reg_q);
		if (sr_reg_q == '0) sr = POOL_W'(1);
		else if (32'(sr_reg_q) > MAX_POOL) sr = POOL_W'(MAX_POOL);
		else sr = POOL_W'(sr_reg_q);
		if (sc_reg_q == '0) sc = POOL_W'(1);
		else if (32'(sc_reg_q) > MAX_POOL) sc = POOL_W'(MAX_POOL);
		else sc = POOL_W'(sc_reg_q);
	end

	assign cfg_hit = cfg_write && (cfg_index <= mpa_pkg::REG_STRIDE_COLS);

	// A window closes when both the row and the column reach their next window end.
	assign hit = (NE_W'(r_q) == nre_q) && (NE_W'(c_q) == nce_q);
	assign in_ready = (state_q == ST_IDLE) && !restart_q && !(hit && out_valid_q);
	assign accept = in_valid && in_ready;

	// The current position is the last sample of the frame.
	assign frame_end = (c_q == iw - DIM_W'(1)) && (r_q == ih - DIM_W'(1)) &&
		(ch_q == nc - CH_W'(1));

	// Last window of the frame: last channel, no further window end in either axis.
	assign row_reach = (NE_W + 1)'(nre_q) + (NE_W + 1)'(sr);
	assign col_reach = (NE_W + 1)'(nce_q) + (NE_W + 1)'(sc);
	assign frame_last_now = (ch_q == nc - CH_W'(1)) &&
		(row_reach >= (NE_W + 1)'(ih)) && (col_reach >= (NE_W + 1)'(iw));

	// Flat index of the window's top-left sample.
	assign up_prod = PROD_W'(ph - POOL_W'(1)) * PROD_W'(iw);
	assign start_flat = flat_q - IW'(up_prod) - IW'(pw) + IW'(1);

	assign scan_last = (kr_q == ph - POOL_W'(1)) && (kc_q == pw - POOL_W'(1));

	assign waddr = plane_addr(r_q, c_q);
	assign raddr = plane_addr(srow_q, scol_q);

	mpa_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(DEPTH)
	) u_plane (
		.clk  (clk),
		.we   (accept),
		.waddr(waddr),
		.wdata(sample),
		.re   (state_q == ST_SCAN),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// Strict greater-than in row-major order keeps the earliest maximum on ties.
	assign take = first_s1 || ($signed(rd_data) > best_q);
	assign new_best = take ? $signed(rd_data) : best_q;
	assign new_idx = take ? flat_s1 : bidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ih_reg_q    <= mpa_pkg::RST_INPUT_HEIGHT;
			iw_reg_q    <= mpa_pkg::RST_INPUT_WIDTH;
			nc_reg_q    <= mpa_pkg::RST_CHANNEL_COUNT;
			ph_reg_q    <= mpa_pkg::RST_POOL_HEIGHT;
			pw_reg_q    <= mpa_pkg::RST_POOL_WIDTH;
			sr_reg_q    <= mpa_pkg::RST_STRIDE_ROWS;
			sc_reg_q    <= mpa_pkg::RST_STRIDE_COLS;
			r_q         <= '0;
			c_q         <= '0;
			ch_q        <= '0;
			nre_q       <= '0;
			nce_q       <= '0;
			flat_q      <= '0;
			oidx_q      <= '0;
			restart_q   <= 1'b1;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_write) begin
				case (cfg_index)
					mpa_pkg::REG_INPUT_HEIGHT:  ih_reg_q <= cfg_data;
					mpa_pkg::REG_INPUT_WIDTH:   iw_reg_q <= cfg_data;
					mpa_pkg::REG_CHANNEL_COUNT: nc_reg_q <= cfg_data;
					mpa_pkg::REG_POOL_HEIGHT:   ph_reg_q <= cfg_data[mpa_pkg::POOL_REG_W-1:0];
					mpa_pkg::REG_POOL_WIDTH:    pw_reg_q <= cfg_data[mpa_pkg::POOL_REG_W-1:0];
					mpa_pkg::REG_STRIDE_ROWS:   sr_reg_q <= cfg_data[mpa_pkg::POOL_REG_W-1:0];
					mpa_pkg::REG_STRIDE_COLS:   sc_reg_q <= cfg_data[mpa_pkg::POOL_REG_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (cfg_hit) begin
						restart_q <= 1'b1;
						r_q       <= '0;
						c_q       <= '0;
						ch_q      <= '0;
					end else if (restart_q) begin
						// Frame start: trackers are loaded from the settings now in place.
						restart_q <= 1'b0;
						r_q       <= '0;
						c_q       <= '0;
						ch_q      <= '0;
						flat_q    <= '0;
						oidx_q    <= '0;
						nre_q     <= NE_W'(ph) - NE_W'(1);
						nce_q     <= NE_W'(pw) - NE_W'(1);
					end else if (accept) begin
						if (hit) begin
							state_q <= ST_SCAN;
						end
						if (frame_end) begin
							flat_q <= '0;
							oidx_q <= '0;
						end else begin
							flat_q <= flat_q + IW'(1);
							if (hit) begin
								oidx_q <= oidx_q + IW'(1);
							end
						end
						if (c_q == iw - DIM_W'(1)) begin
							c_q   <= '0;
							nce_q <= NE_W'(pw) - NE_W'(1);
							if (r_q == ih - DIM_W'(1)) begin
								r_q   <= '0;
								nre_q <= NE_W'(ph) - NE_W'(1);
								if (ch_q == nc - CH_W'(1)) begin
									ch_q <= '0;
								end else begin
									ch_q <= ch_q + CH_W'(1);
								end
							end else begin
								r_q <= r_q + DIM_W'(1);
								if (NE_W'(r_q) == nre_q) begin
									nre_q <= nre_q + NE_W'(sr);
								end
							end
						end else begin
							c_q <= c_q + DIM_W'(1);
							if (NE_W'(c_q) == nce_q) begin
								nce_q <= nce_q + NE_W'(sc);
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: ;
				default: state_q <= ST_IDLE;
			endcase

			if (valid_s1 && last_s1) begin
				out_valid_q <= 1'b1;
				state_q     <= ST_IDLE;
			end
		end
	end

	// Datapath registers: window scan, compare stage and result word.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && hit) begin
			srow_q     <= DIM_W'(NE_W'(r_q) - NE_W'(ph) + NE_W'(1));
			scol_q     <= DIM_W'(NE_W'(c_q) - NE_W'(pw) + NE_W'(1));
			c0_q       <= DIM_W'(NE_W'(c_q) - NE_W'(pw) + NE_W'(1));
			kr_q       <= '0;
			kc_q       <= '0;
			sflat_q    <= start_flat;
			rstep_q    <= IW'(iw) - IW'(pw) + IW'(1);
			oidx_hit_q <= oidx_q;
			last_hit_q <= frame_last_now;
		end
		if (state_q == ST_SCAN) begin
			first_s1 <= (kr_q == '0) && (kc_q == '0);
			last_s1  <= scan_last;
			flat_s1  <= sflat_q;
			if (kc_q == pw - POOL_W'(1)) begin
				kc_q    <= '0;
				kr_q    <= kr_q + POOL_W'(1);
				scol_q  <= c0_q;
				srow_q  <= srow_q + DIM_W'(1);
				sflat_q <= sflat_q + rstep_q;
			end else begin
				kc_q    <= kc_q + POOL_W'(1);
				scol_q  <= scol_q + DIM_W'(1);
				sflat_q <= sflat_q + IW'(1);
			end
		end
		if (valid_s1) begin
			best_q <= new_best;
			bidx_q <= new_idx;
		end
		if (valid_s1 && last_s1) begin
			out_value_q <= new_best;
			out_win_q   <= new_idx;
			out_oidx_q  <= oidx_hit_q;
			out_last_q  <= last_hit_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign max_value    = out_value_q;
	assign winner_index = out_win_q;
	assign output_index = out_oidx_q;
	assign frame_last   = out_last_q;

	a_hit_needs_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit) |-> !out_valid_q)
		else $error("window closed while the output register was full");

	a_hit_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit) |=> (state_q == ST_SCAN))
		else $error("closing sample did not start a window scan");

	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |-> !out_valid_q)
		else $error("result word would overwrite a pending word");

	a_position_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!restart_q |-> (r_q < ih && c_q < iw && ch_q < nc))
		else $error("sample position outside the configured plane");

endmodule

// ===== design/mpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the channel plane store of the max pooling unit.
// No dependencies.
module mpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== tb/sv/max_pool_2d_argmax_checker.sv =====
`timescale 1ns / 1ps
// Checker for max_pool_2d_argmax_unit. It follows register writes and sample words,
// predicts each pooled result word and compares it with the word the block emits.
// Depends on mpa_pkg.
module max_pool_2d_argmax_checker #(
	parameter int MAX_DIM      = 64,
	parameter int MAX_CHANNELS = 64,
	parameter int MAX_POOL     = 8,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [mpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mpa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [SAMPLE_BITS-1:0]      max_value,
	input  logic [mpa_pkg::IDX_W-1:0]          winner_index,
	input  logic [mpa_pkg::IDX_W-1:0]          output_index,
	input  logic                               frame_last,
	output int                                 fail_count,
	output int                                 pending_count
);
	import mpa_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] max_value;
		logic [IDX_W-1:0]              winner_index;
		logic [IDX_W-1:0]              output_index;
		logic                          frame_last;
	} pool_word_t;

	pool_word_t expected_words[$];
	logic signed [SAMPLE_BITS-1:0] plane_copy [MAX_DIM*MAX_DIM];

	logic [DIM_REG_W-1:0]  height_reg, width_reg, planes_reg;
	logic [POOL_REG_W-1:0] win_rows_reg, win_cols_reg, step_rows_reg, step_cols_reg;
	int row_pos, col_pos, plane_pos;
	int mismatch_total;

	function automatic int fit_range(input int v, input int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic apply_write();
		case (cfg_index)
			REG_INPUT_HEIGHT:  height_reg    = cfg_data[DIM_REG_W-1:0];
			REG_INPUT_WIDTH:   width_reg     = cfg_data[DIM_REG_W-1:0];
			REG_CHANNEL_COUNT: planes_reg    = cfg_data[DIM_REG_W-1:0];
			REG_POOL_HEIGHT:   win_rows_reg  = cfg_data[POOL_REG_W-1:0];
			REG_POOL_WIDTH:    win_cols_reg  = cfg_data[POOL_REG_W-1:0];
			REG_STRIDE_ROWS:   step_rows_reg = cfg_data[POOL_REG_W-1:0];
			REG_STRIDE_COLS:   step_cols_reg = cfg_data[POOL_REG_W-1:0];
			default:           return;
		endcase
		// Any register write starts a new frame.
		row_pos = 0;
		col_pos = 0;
		plane_pos = 0;
	endtask

	// Stores the sample word and, when it closes a window, queues the pooled word.
	task automatic absorb_sample();
		int ih, iw, nc, ph, pw, sr, sc, r, c, ch;
		int r0, c0, br, bc, oh, ow, orow, ocol, kr, kc;
		logic signed [SAMPLE_BITS-1:0] best, v;
		pool_word_t w;
		ih = fit_range(height_reg, MAX_DIM);
		iw = fit_range(width_reg, MAX_DIM);
		nc = fit_range(planes_reg, MAX_CHANNELS);
		ph = fit_range(win_rows_reg, MAX_POOL);
		pw = fit_range(win_cols_reg, MAX_POOL);
		sr = fit_range(step_rows_reg, MAX_POOL);
		sc = fit_range(step_cols_reg, MAX_POOL);
		r = row_pos;
		c = col_pos;
		ch = plane_pos;
		if (r >= ih || c >= iw || ch >= nc) begin
			r = 0;
			c = 0;
			ch = 0;
		end
		plane_copy[r*MAX_DIM + c] = sample;
		if (ph <= ih && pw <= iw && r + 1 >= ph && c + 1 >= pw &&
				(r + 1 - ph) % sr == 0 && (c + 1 - pw) % sc == 0) begin
			oh = (ih - ph) / sr + 1;
			ow = (iw - pw) / sc + 1;
			orow = (r + 1 - ph) / sr;
			ocol = (c + 1 - pw) / sc;
			r0 = r + 1 - ph;
			c0 = c + 1 - pw;
			br = r0;
			bc = c0;
			best = plane_copy[r0*MAX_DIM + c0];
			// Strictly greater only, so the earliest of equal maxima wins.
			for (kr = 0; kr < ph; kr++) begin
				for (kc = 0; kc < pw; kc++) begin
					v = plane_copy[(r0 + kr)*MAX_DIM + c0 + kc];
					if (v > best) begin
						best = v;
						br = r0 + kr;
						bc = c0 + kc;
					end
				end
			end
			w.max_value = best;
			w.winner_index = ch*ih*iw + br*iw + bc;
			w.output_index = ch*oh*ow + orow*ow + ocol;
			w.frame_last = (ch + 1 == nc) && (orow + 1 == oh) && (ocol + 1 == ow);
			expected_words.push_back(w);
		end
		c++;
		if (c >= iw) begin
			c = 0;
			r++;
			if (r >= ih) begin
				r = 0;
				ch++;
				if (ch >= nc)
					ch = 0;
			end
		end
		row_pos = r;
		col_pos = c;
		plane_pos = ch;
	endtask

	task automatic check_word();
		pool_word_t want;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected result word: max_value %0d winner_index %0d output_index %0d frame_last %0d",
				$time, max_value, winner_index, output_index, frame_last);
			mismatch_total++;
			return;
		end
		want = expected_words.pop_front();
		if (max_value !== want.max_value) begin
			$display("%0t: max_value expected %0d got %0d", $time, want.max_value, max_value);
			mismatch_total++;
		end
		if (winner_index !== want.winner_index) begin
			$display("%0t: winner_index expected %0d got %0d", $time, want.winner_index,
				winner_index);
			mismatch_total++;
		end
		if (output_index !== want.output_index) begin
			$display("%0t: output_index expected %0d got %0d", $time, want.output_index,
				output_index);
			mismatch_total++;
		end
		if (frame_last !== want.frame_last) begin
			$display("%0t: frame_last expected %0d got %0d", $time, want.frame_last, frame_last);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_reg = RST_INPUT_HEIGHT;
			width_reg = RST_INPUT_WIDTH;
			planes_reg = RST_CHANNEL_COUNT;
			win_rows_reg = RST_POOL_HEIGHT;
			win_cols_reg = RST_POOL_WIDTH;
			step_rows_reg = RST_STRIDE_ROWS;
			step_cols_reg = RST_STRIDE_COLS;
			row_pos = 0;
			col_pos = 0;
			plane_pos = 0;
			mismatch_total = 0;
			expected_words.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready)
				check_word();
			if (cfg_write)
				apply_write();
			if (in_valid && in_ready)
				absorb_sample();
			fail_count <= mismatch_total;
			pending_count <= expected_words.size();
		end
	end

endmodule

// ===== tb/sv/max_pool_2d_argmax_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for max_pool_2d_argmax_unit: writes the geometry registers, sends
// sample words under random pacing and reports the checker's verdict.
// Depends on mpa_pkg, max_pool_2d_argmax_unit and max_pool_2d_argmax_checker.
module max_pool_2d_argmax_unit_tb;
	import mpa_pkg::*;

	localparam int SAMPLE_BITS    = 16;
	localparam int MAX_POOL       = 8;
	localparam int SETTLE_CYCLES  = MAX_POOL * MAX_POOL + 4;
	localparam int RUN_LIMIT      = 1000000;
	localparam int WORDS_PER_MODE = 560;

	// Two 3x3 planes: minimum-value ties, a maximum shared by two rows, zero
	// against minus one, then a plane of equal values.
	localparam logic [18*16-1:0] TIE_PLANES = {
		16'h8000, 16'h8000, 16'h7FFF,
		16'h8000, 16'h8000, 16'h7FFF,
		16'h0000, 16'hFFFF, 16'h7FFF,
		16'h0005, 16'h0005, 16'h0005,
		16'h0005, 16'h0005, 16'h0005,
		16'h0005, 16'h0005, 16'h0005
	};

	typedef struct packed {
		logic [6:0] rows;
		logic [6:0] cols;
		logic [6:0] planes;
		logic [6:0] win_rows;
		logic [6:0] win_cols;
		logic [6:0] step_rows;
		logic [6:0] step_cols;
	} geometry_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_write;
	cfg_index_t                    cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] max_value;
	logic [IDX_W-1:0]              winner_index;
	logic [IDX_W-1:0]              output_index;
	logic                          frame_last;
	int                            fail_count;
	int                            pending_count;
	int                            send_gap_pct = 16;
	int                            stall_pct = 79;
	int                            cycle_count;

	max_pool_2d_argmax_unit #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.max_value(max_value), .winner_index(winner_index),
		.output_index(output_index), .frame_last(frame_last)
	);

	max_pool_2d_argmax_checker #(.SAMPLE_BITS(SAMPLE_BITS)) pool_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.max_value(max_value), .winner_index(winner_index),
		.output_index(output_index), .frame_last(frame_last),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	function automatic logic [15:0] pick_sample();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return 16'($urandom);
		// A narrow range makes equal maxima inside a window common.
		if (roll < 75)
			return 16'($urandom_range(6)) - 16'd3;
		case ($urandom_range(3))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'hFFFF;
			default: return 16'h0000;
		endcase
	endfunction

	// Out-of-range codes exercise the clamping of each dimension.
	function automatic logic [6:0] draw_dim(input int wide_planes);
		int roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return 7'd0;
		if (roll < 12)
			return 7'($urandom_range(64, 127));
		if (wide_planes != 0 && roll < 25)
			return 7'($urandom_range(9, 20));
		return wide_planes != 0 ? 7'($urandom_range(1, 8)) : 7'($urandom_range(1, 3));
	endfunction

	function automatic logic [6:0] draw_window();
		int roll;
		roll = $urandom_range(99);
		if (roll < 6)
			return 7'd0;
		if (roll < 12)
			return 7'($urandom_range(9, 127));
		if (roll < 20)
			return 7'd8;
		return 7'($urandom_range(1, 4));
	endfunction

	function automatic geometry_t draw_geometry();
		geometry_t g;
		g.rows = draw_dim(1);
		g.cols = draw_dim(1);
		g.planes = draw_dim(0);
		g.win_rows = draw_window();
		g.win_cols = draw_window();
		g.step_rows = draw_window();
		g.step_cols = draw_window();
		return g;
	endfunction

	task automatic push_sample(input logic [15:0] v);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Waits until every predicted word has left the block, then lets a window scan finish.
	task automatic settle_block();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [6:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input geometry_t g);
		settle_block();
		write_reg(REG_INPUT_HEIGHT, g.rows);
		write_reg(REG_INPUT_WIDTH, g.cols);
		write_reg(REG_CHANNEL_COUNT, g.planes);
		write_reg(REG_POOL_HEIGHT, g.win_rows);
		write_reg(REG_POOL_WIDTH, g.win_cols);
		write_reg(REG_STRIDE_ROWS, g.step_rows);
		write_reg(REG_STRIDE_COLS, g.step_cols);
		cfg_write <= 1'b0;
	endtask

	task automatic run_phase(input geometry_t g, input int count, input bit hold_midway);
		int i;
		configure(g);
		for (i = 0; i < count; i++) begin
			if (hold_midway && i == count / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_count != 0);
			end
			push_sample(pick_sample());
		end
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int i, mode, sent, span;
		geometry_t g;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_INPUT_HEIGHT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		g = '{7'd3, 7'd3, 7'd2, 7'd2, 7'd2, 7'd1, 7'd1};
		configure(g);
		for (i = 0; i < 18; i++)
			push_sample(TIE_PLANES[(17 - i)*16 +: 16]);
		// A window larger than the plane yields no result words.
		g = '{7'd2, 7'd2, 7'd1, 7'd3, 7'd3, 7'd1, 7'd1};
		configure(g);
		for (i = 0; i < 4; i++)
			push_sample(pick_sample());

		// Largest dimensions, windows and strides, with clamped codes.
		g = '{7'd127, 7'd1, 7'd1, 7'd8, 7'd1, 7'd1, 7'd1};
		run_phase(g, 64, 1'b0);
		g = '{7'd1, 7'd64, 7'd1, 7'd1, 7'd8, 7'd1, 7'd8};
		run_phase(g, 64, 1'b0);
		g = '{7'd1, 7'd1, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0};
		run_phase(g, 64, 1'b1);
		g = '{7'd8, 7'd8, 7'd1, 7'd8, 7'd8, 7'd8, 7'd8};
		run_phase(g, 64, 1'b0);

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_gap_pct = 16;
					stall_pct = 79;
				end
				1: begin
					send_gap_pct = 79;
					stall_pct = 16;
				end
				default: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < WORDS_PER_MODE) begin
				span = $urandom_range(40, 160);
				run_phase(draw_geometry(), span, mode == 0 && sent == 0);
				sent += span;
			end
		end

		settle_block();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/mpa_pkg.sv
design/mpa_ram.sv
design/max_pool_2d_argmax_unit.sv
tb/sv/max_pool_2d_argmax_checker.sv
tb/sv/max_pool_2d_argmax_unit_tb.sv
